FILE: hdl/rfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rfa_pkg;

  // Operation codes carried on the kind port.
  localparam logic [1:0] OP_SUM  = 2'd0;
  localparam logic [1:0] OP_DIFF = 2'd1;
  localparam logic [1:0] OP_PROD = 2'd2;
  localparam logic [1:0] OP_QUOT = 2'd3;

endpackage
`default_nettype wire

FILE: hdl/rfa_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider that produces one quotient bit in each cycle.
module rfa_divider #(
  parameter int W = 15
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         go,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  dvs;
  logic [W-1:0]  quo;
  logic [W-1:0]  rem;
  logic [CW-1:0] count;
  logic          running;
  logic [W:0]    trial;
  logic [W:0]    diff;

  always_comb begin
    trial = {rem, quo[W-1]};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      running <= 1'b0;
      count   <= '0;
    end else if (go) begin
      running <= 1'b1;
      dvs     <= divisor;
      quo     <= dividend;
      rem     <= '0;
      count   <= CW'(W);
    end else if (running) begin
      if (diff[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end else begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end
      count <= count - CW'(1);
      if (count == CW'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  assert property (@(posedge clk) disable iff (rst) running |-> count != '0)
    else $error("divider running with a zero count");

  assert property (@(posedge clk) disable iff (rst) go |-> !running)
    else $error("divider started while still running");

  assert property (@(posedge clk) disable iff (rst) done |-> !running)
    else $error("divider finished while still running");

endmodule
`default_nettype wire

FILE: hdl/rational_fraction_alu_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Direction | Handshake          | Payload
// request   | in        | start, busy        | kind, first/second numerator and denominator
// result    | out       | done (one cycle)   | result_numerator, result_denominator,
//           |           |                    | equals_one, error_flag
//
// A request runs through a small sequencer that shares one restoring divider for every
// greatest common divisor step and every exact division, and one 16 by 16 multiplier.
// The divider always runs OPERAND_BITS steps per division, each Euclid step is one
// division, and each reduced pair adds two exact divisions; the divider sets the time.
// A request with a zero denominator or divisor goes straight to the finish state; a
// sum or difference needs one reduction and a product or quotient, four.
// Reset clears the sequencer; busy is low after reset. The receiver cannot stall: the
// result is shown for exactly one cycle with done high, and busy falls in that cycle.
module rational_fraction_alu_core #(
  parameter int OPERAND_BITS = 15
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               kind,
  input  wire logic [14:0]              first_numerator,
  input  wire logic [14:0]              first_denominator,
  input  wire logic [14:0]              second_numerator,
  input  wire logic [14:0]              second_denominator,
  output logic                          done,
  output logic signed [31:0]            result_numerator,
  output logic [29:0]                   result_denominator,
  output logic                          equals_one,
  output logic                          error_flag
);

  localparam int W = OPERAND_BITS;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_GCD    = 4'd1;   // Euclid step: x mod y
  localparam logic [3:0] S_DIVX   = 4'd2;   // x0 / g
  localparam logic [3:0] S_DIVY   = 4'd3;   // y0 / g
  localparam logic [3:0] S_MUL1   = 4'd4;
  localparam logic [3:0] S_MUL2   = 4'd5;
  localparam logic [3:0] S_FINISH = 4'd6;
  localparam logic [3:0] S_WAIT   = 4'd7;

  logic [3:0] state;
  logic [3:0] ret_state;   // selects the step taken once a divider result lands
  logic [1:0] op;
  logic [W-1:0] a, b, c, d;
  logic [2:0] phase;       // which pair the gcd engine works on
  logic [W-1:0] gx, gy, x0, y0, g;
  logic       div_go;
  logic [W-1:0] div_n, div_d, div_q, div_r;
  logic       div_done;
  logic [31:0] prod1, prod2;
  logic       is_req;

  rfa_divider #(.W(W)) u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(div_n), .divisor(div_d),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  assign is_req = start && !busy;
  assign busy   = (state != S_IDLE);

  // Operand pair for each phase. Sum/difference: phase 0 is gcd(b,d), then l/b.
  // Product: phases 0..3 are (a,b), (c,d), (c,b), (a,d).
  function automatic logic [2*W-1:0] pair_of(input logic [2:0] ph, input logic [W-1:0] pa,
                                             input logic [W-1:0] pb, input logic [W-1:0] pc,
                                             input logic [W-1:0] pd);
    logic [2*W-1:0] r;
    unique case (ph)
      3'd0:    r = {pa, pb};
      3'd1:    r = {pc, pd};
      3'd2:    r = {pc, pb};
      default: r = {pa, pd};
    endcase
    return r;
  endfunction

  logic [2*W-1:0] nxt_pair;
  logic [2:0]     nxt_phase;
  always_comb nxt_phase = phase + 3'd1;
  // The third pair needs the c that is being written back in the same cycle.
  always_comb nxt_pair  = pair_of(nxt_phase, a, b, (phase == 3'd1) ? x0 : c, d);

  logic [W-1:0] lcm_b;   // b / g for sum/difference
  logic [15:0]  mul_a, mul_b;
  logic [31:0]  mul_p;
  always_comb mul_p = {16'd0, mul_a} * {16'd0, mul_b};

  always_ff @(posedge clk) begin
    div_go <= 1'b0;
    done   <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (is_req) begin
            op <= kind;
            a  <= first_numerator[W-1:0];
            b  <= first_denominator[W-1:0];
            if (kind == rfa_pkg::OP_QUOT) begin
              c <= second_denominator[W-1:0];
              d <= second_numerator[W-1:0];
            end else begin
              c <= second_numerator[W-1:0];
              d <= second_denominator[W-1:0];
            end
            phase <= 3'd0;
            if (first_denominator[W-1:0] == '0 || second_denominator[W-1:0] == '0 ||
                (kind == rfa_pkg::OP_QUOT && second_numerator[W-1:0] == '0)) begin
              result_numerator   <= '0;
              result_denominator <= '0;
              equals_one         <= 1'b0;
              error_flag         <= 1'b1;
              state              <= S_FINISH;
            end else if (kind == rfa_pkg::OP_SUM || kind == rfa_pkg::OP_DIFF) begin
              gx <= first_denominator[W-1:0];
              gy <= second_denominator[W-1:0];
              x0 <= first_denominator[W-1:0];
              y0 <= second_denominator[W-1:0];
              state <= S_GCD;
              error_flag <= 1'b0;
            end else begin
              gx <= first_numerator[W-1:0];
              gy <= first_denominator[W-1:0];
              x0 <= first_numerator[W-1:0];
              y0 <= first_denominator[W-1:0];
              state <= S_GCD;
              error_flag <= 1'b0;
            end
          end
        end
        S_GCD: begin
          // Skip a product reduction when either value is zero.
          if (op[1] && (x0 == '0 || y0 == '0)) begin
            state <= S_MUL1;
          end else if (gy == '0) begin
            g      <= gx;
            div_n  <= x0;
            div_d  <= gx;
            div_go <= 1'b1;
            ret_state <= S_DIVX;
            state  <= S_WAIT;
          end else begin
            div_n  <= gx;
            div_d  <= gy;
            div_go <= 1'b1;
            ret_state <= S_GCD;
            state  <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_done) begin
            unique case (ret_state)
              S_GCD: begin
                gx    <= gy;
                gy    <= div_r;
                state <= S_GCD;
              end
              S_DIVX: begin
                if (!op[1]) begin
                  lcm_b <= div_q;
                  // l/d = b/g is kept in lcm_b; next comes l/b = d/g.
                  div_n  <= y0;
                  div_d  <= g;
                  div_go <= 1'b1;
                  ret_state <= S_DIVY;
                end else begin
                  x0     <= div_q;
                  div_n  <= y0;
                  div_d  <= g;
                  div_go <= 1'b1;
                  ret_state <= S_DIVY;
                end
              end
              default: begin
                y0    <= div_q;
                state <= S_MUL1;
              end
            endcase
          end
        end
        S_MUL1: begin
          if (!op[1]) begin
            // y0 = d/g = l/b; x0 = b. prod1 = a*(l/b), later prod2 = c*(b/g).
            mul_a <= {{(16-W){1'b0}}, a};
            mul_b <= {{(16-W){1'b0}}, y0};
            state <= S_MUL2;
          end else begin
            // Write the reduced pair back, then move to the next pair.
            unique case (phase)
              3'd0:    begin a <= x0; b <= y0; end
              3'd1:    begin c <= x0; d <= y0; end
              3'd2:    begin c <= x0; b <= y0; end
              default: begin a <= x0; d <= y0; end
            endcase
            if (phase == 3'd3) begin
              state <= S_MUL2;
            end else begin
              phase <= nxt_phase;
              gx <= nxt_pair[2*W-1:W];
              gy <= nxt_pair[W-1:0];
              x0 <= nxt_pair[2*W-1:W];
              y0 <= nxt_pair[W-1:0];
              state <= S_GCD;
            end
          end
        end
        S_MUL2: begin
          // Multiplier passes, registered in between: three for sum/difference, two for product.
          if (phase != 3'd7 && !op[1]) begin
            prod1 <= mul_p;
            mul_a <= {{(16-W){1'b0}}, c};
            mul_b <= {{(16-W){1'b0}}, lcm_b};
            phase <= 3'd7;
          end else if (phase != 3'd7) begin
            mul_a <= {{(16-W){1'b0}}, a};
            mul_b <= {{(16-W){1'b0}}, c};
            phase <= 3'd7;
            prod1 <= '0;
            ret_state <= S_IDLE;
          end else if (op[1] && ret_state == S_IDLE) begin
            prod1 <= mul_p;
            mul_a <= {{(16-W){1'b0}}, b};
            mul_b <= {{(16-W){1'b0}}, d};
            ret_state <= S_MUL1;
          end else begin
            prod2 <= mul_p;
            if (!op[1]) begin
              // Denominator l = (b/g)*d.
              mul_a <= {{(16-W){1'b0}}, lcm_b};
              mul_b <= {{(16-W){1'b0}}, d};
            end
            state <= S_FINISH;
            phase <= 3'd6;
          end
        end
        S_FINISH: begin
          if (phase == 3'd6) begin
            if (!op[1]) begin
              result_numerator   <= (op == rfa_pkg::OP_SUM) ? prod1 + prod2 : prod1 - prod2;
              result_denominator <= mul_p[29:0];
              equals_one <= (((op == rfa_pkg::OP_SUM) ? prod1 + prod2 : prod1 - prod2)
                             == mul_p);
            end else begin
              result_numerator   <= prod1;
              result_denominator <= prod2[29:0];
              equals_one <= (prod1 == prod2);
            end
            phase <= 3'd5;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // For product, prod2 is written at the last multiply as b*d.
  property p_done_idle;
    @(posedge clk) disable iff (rst) done |-> state == S_IDLE;
  endproperty
  assert property (p_done_idle) else $error("done while sequencer busy");

  assert property (@(posedge clk) disable iff (rst) is_req |=> busy)
    else $error("request accepted but not busy");

  assert property (@(posedge clk) disable iff (rst) done && error_flag |-> !equals_one)
    else $error("equals_one set on an error result");

  assert property (@(posedge clk) disable iff (rst) div_go |-> state == S_WAIT)
    else $error("divider started outside a wait");

endmodule
`default_nettype wire

FILE: tb/fraction_checker.sv
`timescale 1ns / 1ps
module fraction_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         kind,
  input  logic [14:0]        first_numerator,
  input  logic [14:0]        first_denominator,
  input  logic [14:0]        second_numerator,
  input  logic [14:0]        second_denominator,
  input  logic               done,
  input  logic signed [31:0] result_numerator,
  input  logic [29:0]        result_denominator,
  input  logic               equals_one,
  input  logic               error_flag,
  output int                 failures,
  output int                 pending
);

  typedef struct packed {
    logic [31:0] num;
    logic [29:0] den;
    logic        one;
    logic        err;
  } fraction_t;

  fraction_t expected_fractions[$];
  int        failure_count = 0;

  function automatic logic [31:0] gcd_of(logic [31:0] x, logic [31:0] y);
    logic [31:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // Cancel the common factor of a pair; a pair holding a zero is left alone.
  function automatic void cancel(inout logic [31:0] x, inout logic [31:0] y);
    logic [31:0] g;
    if (x == 0 || y == 0) return;
    g = gcd_of(x, y);
    x = x / g;
    y = y / g;
  endfunction

  function automatic fraction_t compute_fraction(logic [1:0] op, logic [31:0] a,
                                                 logic [31:0] b, logic [31:0] c,
                                                 logic [31:0] d);
    fraction_t f;
    logic [31:0] l, n, m, t;
    logic        e;
    n = 0;
    m = 0;
    e = (b == 0) || (d == 0) || (op == rfa_pkg::OP_QUOT && c == 0);
    if (!e) begin
      if (op == rfa_pkg::OP_SUM || op == rfa_pkg::OP_DIFF) begin
        l = (b / gcd_of(b, d)) * d;
        n = (op == rfa_pkg::OP_SUM) ? a * (l / b) + c * (l / d) : a * (l / b) - c * (l / d);
        m = l;
      end else begin
        if (op == rfa_pkg::OP_QUOT) begin
          t = c;
          c = d;
          d = t;
        end
        cancel(a, b);
        cancel(c, d);
        cancel(c, b);
        cancel(a, d);
        n = a * c;
        m = b * d;
      end
    end
    f.num = n;
    f.den = m[29:0];
    f.one = !e && (n == m);
    f.err = e;
    return f;
  endfunction

  assign pending  = expected_fractions.size();
  assign failures = failure_count;

  always @(posedge clk) begin
    fraction_t want;
    if (!rst && start && !busy)
      expected_fractions.push_back(compute_fraction(kind, {17'd0, first_numerator},
        {17'd0, first_denominator}, {17'd0, second_numerator},
        {17'd0, second_denominator}));
    if (!rst && done) begin
      if (expected_fractions.size() == 0) begin
        $display("%0t: result with nothing expected: %h/%h", $time, result_numerator,
                 result_denominator);
        failure_count++;
      end else begin
        want = expected_fractions.pop_front();
        if (result_numerator !== want.num || result_denominator !== want.den ||
            equals_one !== want.one || error_flag !== want.err) begin
          $display("%0t: expected num %h den %h one %b err %b, got num %h den %h one %b err %b",
                   $time, want.num, want.den, want.one, want.err, result_numerator,
                   result_denominator, equals_one, error_flag);
          failure_count++;
        end
      end
    end
  end
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Drives requests into the fraction unit with random gaps and lets the checker
// module predict and compare every result. The unit can never be held off on its
// result side, so only the request side idles.
module testbench;

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic               busy;
  logic [1:0]         kind = rfa_pkg::OP_SUM;
  logic [14:0]        first_numerator = 0;
  logic [14:0]        first_denominator = 0;
  logic [14:0]        second_numerator = 0;
  logic [14:0]        second_denominator = 0;
  logic               done;
  logic signed [31:0] result_numerator;
  logic [29:0]        result_denominator;
  logic               equals_one;
  logic               error_flag;
  int                 failures;
  int                 pending;
  int                 idle_cycles = 0;

  // The watchdog limit: far longer than a worst-case request and the longest
  // sender gap take together, so this leaves a wide margin.
  localparam int IDLE_LIMIT = 20000;

  always #2 clk = ~clk;

  rational_fraction_alu_core dut (.*);
  fraction_checker checker_i (.*);

  // Count cycles in which nothing is accepted on either side.
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Pick an operand: mostly small values, so that common factors are frequent,
  // with the extremes and full-range values mixed in.
  function automatic logic [14:0] pick_operand();
    int r;
    r = int'($urandom_range(0, 9));
    if (r == 0) return 15'd0;
    if (r == 1) return 15'h7fff;
    if (r < 5) return 15'($urandom_range(1, 60));
    if (r < 7) return 15'($urandom_range(1, 12) * $urandom_range(1, 40));
    return 15'($urandom);
  endfunction

  // Present one request, hold it until it is accepted, then insert a random gap.
  task automatic send_request(logic [1:0] op, logic [14:0] a, logic [14:0] b,
                              logic [14:0] c, logic [14:0] d);
    int gap;
    start <= 1;
    kind <= op;
    first_numerator <= a;
    first_denominator <= b;
    second_numerator <= c;
    second_denominator <= d;
    do @(posedge clk); while (busy);
    gap = ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 60))
                                      : int'($urandom_range(0, 2));
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic [1:0] op;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed requests: every operation, the zero denominator and zero divisor
    // cases, zero operands in reductions, a negative difference, and the extremes.
    for (int k = 0; k < 4; k++) begin
      op = k[1:0];
      send_request(op, 15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff);
      send_request(op, 15'd3, 15'd4, 15'd5, 15'd6);
      send_request(op, 15'd0, 15'd7, 15'd0, 15'd9);
      send_request(op, 15'd1, 15'd0, 15'd2, 15'd3);
      send_request(op, 15'd1, 15'd32767, 15'd2, 15'd32766);
    end
    send_request(rfa_pkg::OP_DIFF, 15'd1, 15'd4, 15'd3, 15'd4);
    send_request(rfa_pkg::OP_QUOT, 15'd5, 15'd7, 15'd0, 15'd3);
    send_request(rfa_pkg::OP_QUOT, 15'd6, 15'd8, 15'd9, 15'd12);
    send_request(rfa_pkg::OP_PROD, 15'd4, 15'd6, 15'd9, 15'd2);
    send_request(rfa_pkg::OP_SUM, 15'd1, 15'd1, 15'd1, 15'd0);

    for (int i = 0; i < 1025; i++) begin
      op = 2'($urandom_range(0, 3));
      send_request(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
    start <= 0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (failures == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
